>>> design/sha_pkg.sv
// shared types, codes and constants for the sha-256 byte stream hasher
// no dependencies; the datapath, controller and top level refer to this package by scoped names
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned LEN_BITS  = 61;

   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] FILL_LEN   = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [7:0] PAD_MARK   = 8'h80;

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [0:7][31:0] INIT_H = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   typedef enum logic [1:0] {
      BYTE_MSG,
      BYTE_MARK,
      BYTE_ZERO
   } byte_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD
   } ctrl_state_type;

   typedef struct packed {
      logic         put_byte;
      byte_sel_type byte_sel;
      logic         count_len;
      logic         write_len;
      logic         start_block;
      logic         round;
      logic [5:0]   round_idx;
      logic         fold;
      logic         finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       out_busy;
   } dp_stat_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

`default_nettype wire

>>> design/sha_req_if.sv
// request channel: one message byte beat with its flags
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, message_byte, has_byte, end_of_message, input ready);
   modport sink (input valid, message_byte, has_byte, end_of_message, output ready);
endinterface

`default_nettype wire

>>> design/sha_rsp_if.sv
// response channel: one digest word beat
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source (output valid, digest_word, word_number, last_word, input ready);
   modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

`default_nettype wire

>>> design/sha_dp.sv
// datapath: block/schedule words, working variables, chain value, length and digest output
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          message_byte,
   input  wire sha_pkg::dp_cmd_type cmd,
   output sha_pkg::dp_stat_type     stat,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [31:0]              digest_word,
   output logic [2:0]               word_number,
   output logic                     last_word
);

   logic [31:0] word_ff [16];
   logic [31:0] word_in [16];
   logic [31:0] wv_ff [8];
   logic [31:0] wv_in [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] digest_ff [8];
   logic [31:0] digest_in [8];
   logic [5:0]  fill_ff, fill_in;
   logic [sha_pkg::LEN_BITS-1:0] len_ff, len_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_cnt_ff, out_cnt_in;

   logic [7:0]  byte_val;
   logic [3:0]  byte_word;
   logic [1:0]  byte_lane;
   logic [63:0] len_bits;
   logic [31:0] wt, sig0, sig1;
   logic [31:0] bsig0, bsig1, ch, maj, t1, t2;

   always_comb begin
      case (cmd.byte_sel)
         sha_pkg::BYTE_MSG:  byte_val = message_byte;
         sha_pkg::BYTE_MARK: byte_val = sha_pkg::PAD_MARK;
         default:            byte_val = 8'h00;
      endcase
   end

   assign byte_word = fill_ff[5:2];
   assign byte_lane = fill_ff[1:0];
   assign len_bits  = {len_ff, 3'b000};

   // message schedule over a 16-word sliding window, oldest word at index 0
   assign sig0 = sha_pkg::rotr(word_ff[1], 7) ^ sha_pkg::rotr(word_ff[1], 18)
                 ^ (word_ff[1] >> 3);
   assign sig1 = sha_pkg::rotr(word_ff[14], 17) ^ sha_pkg::rotr(word_ff[14], 19)
                 ^ (word_ff[14] >> 10);
   assign wt   = (cmd.round_idx[5:4] == 2'b00) ? word_ff[0]
                 : word_ff[0] + sig0 + word_ff[9] + sig1;

   assign bsig1 = sha_pkg::rotr(wv_ff[4], 6) ^ sha_pkg::rotr(wv_ff[4], 11)
                  ^ sha_pkg::rotr(wv_ff[4], 25);
   assign ch    = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
   assign t1    = wv_ff[7] + bsig1 + ch + sha_pkg::ROUND_K[cmd.round_idx] + wt;
   assign bsig0 = sha_pkg::rotr(wv_ff[0], 2) ^ sha_pkg::rotr(wv_ff[0], 13)
                  ^ sha_pkg::rotr(wv_ff[0], 22);
   assign maj   = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
   assign t2    = bsig0 + maj;

   always_comb begin
      word_in = word_ff;
      if (cmd.put_byte) begin
         case (byte_lane)
            2'd0:    word_in[byte_word][31:24] = byte_val;
            2'd1:    word_in[byte_word][23:16] = byte_val;
            2'd2:    word_in[byte_word][15:8]  = byte_val;
            default: word_in[byte_word][7:0]   = byte_val;
         endcase
      end
      if (cmd.write_len) begin
         word_in[14] = len_bits[63:32];
         word_in[15] = len_bits[31:0];
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            word_in[i] = word_ff[i + 1];
         end
         word_in[15] = wt;
      end
   end

   always_comb begin
      wv_in = wv_ff;
      if (cmd.start_block) begin
         wv_in = chain_ff;
      end else if (cmd.round) begin
         wv_in[7] = wv_ff[6];
         wv_in[6] = wv_ff[5];
         wv_in[5] = wv_ff[4];
         wv_in[4] = wv_ff[3] + t1;
         wv_in[3] = wv_ff[2];
         wv_in[2] = wv_ff[1];
         wv_in[1] = wv_ff[0];
         wv_in[0] = t1 + t2;
      end
   end

   always_comb begin
      chain_in  = chain_ff;
      digest_in = digest_ff;
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + wv_ff[i];
         end
      end
      if (cmd.finish) begin
         for (int i = 0; i < 8; i++) begin
            digest_in[i] = chain_ff[i] + wv_ff[i];
            chain_in[i]  = sha_pkg::INIT_H[i];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      len_in  = len_ff;
      if (cmd.put_byte) begin
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.write_len || cmd.finish) begin
         fill_in = '0;
      end
      // count saturates at all ones
      if (cmd.count_len && (len_ff != '1)) begin
         len_in = len_ff + {{(sha_pkg::LEN_BITS-1){1'b0}}, 1'b1};
      end
      if (cmd.finish) begin
         len_in = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_cnt_in   = out_cnt_ff;
      if (out_valid_ff && rsp_ready) begin
         out_cnt_in = out_cnt_ff + 3'd1;
         if (out_cnt_ff == 3'd7) begin
            out_valid_in = 1'b0;
         end
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      wv_ff     <= wv_in;
      digest_ff <= digest_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha_pkg::INIT_H[i];
         end
         fill_ff      <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
         out_cnt_ff   <= '0;
      end else begin
         chain_ff     <= chain_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

   assign stat.fill     = fill_ff;
   assign stat.out_busy = out_valid_ff;

   assign rsp_valid   = out_valid_ff;
   assign digest_word = digest_ff[out_cnt_ff];
   assign word_number = out_cnt_ff;
   assign last_word   = (out_cnt_ff == 3'd7);

endmodule

`default_nettype wire

>>> design/sha_ctrl.sv
// controller: sequences byte intake, padding, the 64 rounds and the chain update
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_has_byte,
   input  wire logic                 req_end,
   input  wire sha_pkg::dp_stat_type stat,
   output sha_pkg::dp_cmd_type       cmd
);

   sha_pkg::ctrl_state_type state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic       pad_ff, pad_in;
   logic       mark_ff, mark_in;
   logic       final_ff, final_in;

   logic block_full;
   logic len_slot;

   assign block_full = (stat.fill == sha_pkg::FILL_LAST);
   assign len_slot   = (stat.fill == sha_pkg::FILL_LEN);

   // next state
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      final_in = final_ff;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_valid) begin
               pad_in  = req_end;
               mark_in = req_end;
               if (req_has_byte && block_full) begin
                  state_in = sha_pkg::ST_ROUND;
               end else if (req_end) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            if (mark_ff) begin
               mark_in = 1'b0;
               if (block_full) begin
                  state_in = sha_pkg::ST_ROUND;
               end
            end else if (len_slot) begin
               pad_in   = 1'b0;
               final_in = 1'b1;
               state_in = sha_pkg::ST_ROUND;
            end else if (block_full) begin
               state_in = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == sha_pkg::ROUND_LAST) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            if (final_ff) begin
               // digest register must be drained before it is overwritten
               if (!stat.out_busy) begin
                  final_in = 1'b0;
                  state_in = sha_pkg::ST_IDLE;
               end
            end else if (pad_ff) begin
               state_in = sha_pkg::ST_PAD;
            end else begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.byte_sel  = sha_pkg::BYTE_ZERO;
      cmd.round_idx = round_ff;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_has_byte) begin
               cmd.put_byte    = 1'b1;
               cmd.byte_sel    = sha_pkg::BYTE_MSG;
               cmd.count_len   = 1'b1;
               cmd.start_block = block_full;
            end
         end
         sha_pkg::ST_PAD: begin
            if (mark_ff) begin
               cmd.put_byte    = 1'b1;
               cmd.byte_sel    = sha_pkg::BYTE_MARK;
               cmd.start_block = block_full;
            end else if (len_slot) begin
               cmd.write_len   = 1'b1;
               cmd.start_block = 1'b1;
            end else begin
               cmd.put_byte    = 1'b1;
               cmd.start_block = block_full;
            end
         end
         sha_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         sha_pkg::ST_FOLD: begin
            if (final_ff) begin
               cmd.finish = !stat.out_busy;
            end else begin
               cmd.fold = 1'b1;
            end
         end
         default: begin
            cmd.round = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         round_ff <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         final_ff <= final_in;
      end
   end

endmodule

`default_nettype wire

>>> design/sha256_byte_stream_hasher.sv
// intake: a byte not completing a block is accepted when offered; a block's last byte is
// followed by 64 rounds at one per cycle and the chain update; no byte is taken meanwhile
// end of message: mark byte, zero pad bytes and length slot, then rounds and chain update
// per padded block; the last chain update is held while an earlier digest drains, then eight
// digest beats at one per cycle while ready is high; next-message bytes are taken meanwhile
// reset: synchronous; chain value returns to the initial hash, counters and handshakes clear
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher (
   input  wire logic clock,
   input  wire logic reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);

   sha_pkg::dp_cmd_type  cmd;
   sha_pkg::dp_stat_type stat;

   sha_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_has_byte (req_chan.has_byte),
      .req_end      (req_chan.end_of_message),
      .stat         (stat),
      .cmd          (cmd)
   );

   sha_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .message_byte (req_chan.message_byte),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .digest_word  (rsp_chan.digest_word),
      .word_number  (rsp_chan.word_number),
      .last_word    (rsp_chan.last_word)
   );

`ifndef SYNTH
   a_start_then_round: assert property (@(posedge clock) disable iff (reset)
      cmd.start_block |=> cmd.round)
      else $error("block start not followed by a round");

   a_finish_idle_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !stat.out_busy)
      else $error("digest overwritten while still draining");

   a_round_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> (!cmd.put_byte && !cmd.write_len && !req_chan.ready))
      else $error("block words written during rounds");

   a_last_beat_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word) |=> !rsp_chan.valid)
      else $error("digest output continues past the last word");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// testbench for sha256_byte_stream_hasher: random and directed byte streams, digest check
// needs the hasher top level and the sha_req_if / sha_rsp_if channel interfaces
`timescale 1ns / 1ps

module tb_top;

   localparam int HOLD_CYCLES   = 600;
   localparam int STALL_LIMIT   = 4000;
   localparam int ITEM_TARGET   = 180;
   localparam int DIGEST_TARGET = 6;
   localparam int TAIL_CYCLES   = 250;

   typedef struct {
      bit [31:0] word;
      bit [2:0]  index;
      bit        last;
   } digest_beat_type;

   // running sha-256 over the accepted beats, plus the queue of digest beats still owed
   class digest_predictor;
      localparam bit [0:7][31:0] IV = {
         32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      localparam bit [0:63][31:0] RK = {
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

      bit [31:0]       chain [8];
      bit [31:0]       block [16];
      bit [5:0]        fill;
      bit [60:0]       length_bytes;
      digest_beat_type expected_beats [$];
      int              errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = IV[i];
         fill = '0;
         length_bytes = '0;
      endfunction

      function bit [31:0] ror(bit [31:0] v, int n);
         return (v >> n) | (v << (32 - n));
      endfunction

      function void compress();
         bit [31:0] w [16];
         bit [31:0] v [8];
         bit [31:0] wt, x, y, s0, s1, ch, mj, t1;
         w = block;
         v = chain;
         for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
               wt = w[t];
            end else begin
               x  = w[(t + 1) % 16];
               y  = w[(t + 14) % 16];
               wt = w[t % 16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[(t + 9) % 16]
                  + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
               w[t % 16] = wt;
            end
            s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + RK[t] + wt;
            s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            for (int j = 7; j > 0; j--) v[j] = v[j - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + s0 + mj;
         end
         for (int i = 0; i < 8; i++) chain[i] += v[i];
      endfunction

      // big-endian packing; the 6-bit fill wraps to zero on a full block
      function void put_byte(bit [7:0] b);
         block[fill[5:2]][8 * (3 - fill[1:0]) +: 8] = b;
         fill++;
         if (fill == 0) compress();
      endfunction

      function void note_input(bit [7:0] data, bit has, bit eom);
         bit [63:0] bit_len;
         if (has) begin
            put_byte(data);
            if (length_bytes != '1) length_bytes++;
         end
         if (!eom) return;
         bit_len = {length_bytes, 3'b000};
         put_byte(8'h80);
         if (fill > 56) begin
            while (fill != 0) put_byte(8'h00);
         end
         while (fill < 56) put_byte(8'h00);
         block[14] = bit_len[63:32];
         block[15] = bit_len[31:0];
         compress();
         for (int i = 0; i < 8; i++)
            expected_beats.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
         restart();
      endfunction

      function void report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endfunction

      function void check_result(bit [31:0] word, bit [2:0] index, bit last);
         digest_beat_type want;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected digest beat %h word %0d", word, index));
            return;
         end
         want = expected_beats.pop_front();
         if (word != want.word)
            report($sformatf("digest word %0d: got %h want %h", want.index, word, want.word));
         if (index != want.index)
            report($sformatf("word number: got %0d want %0d", index, want.index));
         if (last != want.last)
            report($sformatf("last flag on word %0d: got %0b want %0b", want.index, last,
                             want.last));
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   bench_live = 1'b0;
   bit   sender_calm = 1'b0;
   int   items_sent = 0;
   int   digests_sent = 0;
   int   quiet_cycles = 0;

   digest_predictor digest_model = new();

   sha_req_if req_bus ();
   sha_rsp_if rsp_bus ();

   sha256_byte_stream_hasher uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   task send_beat(input bit [7:0] data, input bit has, input bit eom);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.message_byte   <= data;
      req_bus.has_byte       <= has;
      req_bus.end_of_message <= eom;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      digest_model.note_input(data, has, eom);
      if (has || eom) items_sent++;
      if (eom) digests_sent++;
   endtask

   // idle steps with junk bytes are sprinkled in; they never count as items
   task send_message(input int n, input bit bare);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_beat(8'($urandom_range(0, 255)), 1'b1, !bare && (i == n - 1));
      end
      if (bare || n == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (digest_model.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.message_byte   = 8'h00;
      req_bus.has_byte       = 1'b0;
      req_bus.end_of_message = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      bench_live = 1'b1;

      // empty message, junk byte on the bare end marker
      send_beat(8'h5a, 1'b0, 1'b1);
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      send_beat(8'hff, 1'b0, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'ha5, 1'b0, 1'b0);
      send_beat(8'hff, 1'b1, 1'b0);
      send_beat(8'h3c, 1'b0, 1'b1);
      send_beat(8'h80, 1'b1, 1'b1);
      send_beat(8'h01, 1'b1, 1'b0);
      send_beat(8'hfe, 1'b1, 1'b1);

      // sender holds back until every digest is out
      drain();

      items_sent = 0;
      while (items_sent < ITEM_TARGET || digests_sent < DIGEST_TARGET) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         // short messages in three of eight draws, the rest right on the padding boundaries
         case ($urandom_range(0, 7))
            0: n = 55;
            1: n = 56;
            2: n = 63;
            3: n = 64;
            4: n = ($urandom_range(0, 1) == 0) ? 119 : 120;
            default: n = $urandom_range(0, 10);
         endcase
         // keep the total close to the item target
         if (items_sent + n > ITEM_TARGET)
            n = (items_sent < ITEM_TARGET) ? ITEM_TARGET - items_sent : 0;
         send_message(n, $urandom_range(0, 3) == 0);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (digest_model.errors == 0) begin
         $display("sha256_byte_stream_hasher regression: pass");
      end else begin
         $display("sha256_byte_stream_hasher regression: fail");
      end
      $finish;
   end

   // digest side: random stalls, calm stretches, one long hold that backs up the input
   initial begin
      int gap;
      int beats;
      bit held;
      bit calm;
      beats = 0;
      held  = 1'b0;
      calm  = 1'b0;
      rsp_bus.ready = 1'b0;
      wait (bench_live);
      forever begin
         if (beats % 16 == 0) calm = ($urandom_range(0, 2) == 0);
         @(negedge clock);
         if (!held && beats == 40) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end else begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         digest_model.check_result(rsp_bus.digest_word, rsp_bus.word_number,
                                   rsp_bus.last_word);
         beats++;
      end
   end

   always @(posedge clock) begin
      if (bench_live) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("sha256_byte_stream_hasher regression: fail");
            $finish;
         end
      end
   end

endmodule
